// File: hw/rtl/dhke_pkg.sv
`timescale 1ns / 1ps
package dhke_pkg;
	localparam int unsigned WIDTH_DEF = 32;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_A = 2'd1;
	localparam logic [1:0] ST_BAD_B = 2'd2;
	localparam logic [0:0] REG_MODULUS = 1'b0;
	localparam logic [0:0] REG_GENERATOR = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD_GA,
		OP_LOAD_GB,
		OP_LOAD_KEY
	} load_op_t;

	typedef struct packed {
		logic     load;
		load_op_t op;
		logic     reduce_g;
		logic     square;
		logic     mul_step;
		logic     mult;
		logic     shift_exp;
		logic     save_pa;
		logic     save_base;
		logic     save_key;
	} dhke_cmd_t;

	typedef struct packed {
		logic bad_a;
		logic bad_b;
		logic exp_bit;
	} dhke_stat_t;
endpackage

// File: hw/rtl/dhke_datapath.sv
`timescale 1ns / 1ps
module dhke_datapath #(
	parameter int unsigned WIDTH = dhke_pkg::WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    capture,
	input  logic [WIDTH-1:0]        secret_a,
	input  logic [WIDTH-1:0]        secret_b,
	input  logic [WIDTH-1:0]        modulus,
	input  logic [WIDTH-1:0]        generator,
	input  dhke_pkg::dhke_cmd_t     cmd,
	output dhke_pkg::dhke_stat_t    stat,
	output logic [WIDTH-1:0]        public_a,
	output logic [WIDTH-1:0]        public_b,
	output logic [WIDTH-1:0]        shared_key
);
	import dhke_pkg::*;

	logic [WIDTH-1:0] sa_q, sb_q, m_q, g_q, base_q, exp_q, r_q, x_q, y_q, acc_q;
	logic [WIDTH-1:0] acc_dbl, acc_add, one_mod;

	function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
		input logic [WIDTH-1:0] b, input logic [WIDTH-1:0] m);
		logic [WIDTH-1:0] room;
		room = m - b;
		add_mod = (a >= room) ? a - room : a + b;
	endfunction

	assign one_mod = (m_q == {{(WIDTH-1){1'b0}}, 1'b1}) ? '0 : {{(WIDTH-1){1'b0}}, 1'b1};
	assign acc_dbl = add_mod(acc_q, acc_q, m_q);
	assign acc_add = y_q[WIDTH-1] ? add_mod(acc_dbl, x_q, m_q) : acc_dbl;

	assign stat.bad_a = (sa_q >= m_q);
	assign stat.bad_b = (sb_q >= m_q);
	assign stat.exp_bit = exp_q[WIDTH-1];

	always_ff @(posedge clk) begin
		if (capture) begin
			sa_q <= secret_a;
			sb_q <= secret_b;
			m_q <= modulus;
			g_q <= generator;
			public_a <= '0;
			public_b <= '0;
			shared_key <= '0;
		end
		if (cmd.load) begin
			r_q <= one_mod;
			unique case (cmd.op)
				OP_LOAD_GA: begin
					exp_q <= sa_q;
				end
				OP_LOAD_GB: begin
					exp_q <= sb_q;
				end
				default: begin
					base_q <= public_b;
					exp_q <= sa_q;
				end
			endcase
		end
		if (cmd.reduce_g) begin
			x_q <= one_mod;
			y_q <= g_q;
			acc_q <= '0;
		end
		if (cmd.square) begin
			x_q <= r_q;
			y_q <= r_q;
			acc_q <= '0;
		end
		if (cmd.mult) begin
			x_q <= base_q;
			y_q <= r_q;
			acc_q <= '0;
		end
		if (cmd.mul_step) begin
			acc_q <= acc_add;
			y_q <= {y_q[WIDTH-2:0], 1'b0};
		end
		if (cmd.save_pa) r_q <= acc_q;
		if (cmd.save_base) base_q <= acc_q;
		if (cmd.shift_exp) exp_q <= {exp_q[WIDTH-2:0], 1'b0};
		if (cmd.save_key) begin
			if (cmd.op == OP_LOAD_GA) public_a <= r_q;
			else if (cmd.op == OP_LOAD_GB) public_b <= r_q;
			else shared_key <= r_q;
		end
	end
endmodule

// File: hw/rtl/dhke_ctrl.sv
`timescale 1ns / 1ps
module dhke_ctrl #(
	parameter int unsigned WIDTH = dhke_pkg::WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  dhke_pkg::dhke_stat_t stat,
	output logic                 busy,
	output logic                 capture,
	output dhke_pkg::dhke_cmd_t  cmd,
	output logic                 done,
	output logic [1:0]           status
);
	import dhke_pkg::*;

	localparam int unsigned CW = $clog2(WIDTH);

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_RED, S_BASE, S_LOAD, S_SQ, S_MUL, S_STEP, S_NEXT, S_SAVE
	} state_t;

	state_t state_q;
	load_op_t op_q;
	logic [CW-1:0] bit_q, step_q;
	logic pend_mul_q, red_q;
	logic [1:0] status_q;

	assign busy = (state_q != S_IDLE);
	assign capture = start && !busy;
	assign status = status_q;

	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		unique case (state_q)
			S_RED: cmd.reduce_g = 1'b1;
			S_BASE: cmd.save_base = 1'b1;
			S_LOAD: cmd.load = 1'b1;
			S_SQ: cmd.square = 1'b1;
			S_MUL: cmd.mult = 1'b1;
			S_STEP: cmd.mul_step = 1'b1;
			S_NEXT: begin
				cmd.save_pa = 1'b1;
				cmd.shift_exp = !pend_mul_q;
			end
			S_SAVE: cmd.save_key = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_LOAD_GA;
			bit_q <= '0;
			step_q <= '0;
			pend_mul_q <= 1'b0;
			red_q <= 1'b0;
			status_q <= ST_OK;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_CHECK;
				S_CHECK: begin
					op_q <= OP_LOAD_GA;
					if (stat.bad_a) begin
						status_q <= ST_BAD_A;
						done <= 1'b1;
						state_q <= S_IDLE;
					end else if (stat.bad_b) begin
						status_q <= ST_BAD_B;
						done <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						status_q <= ST_OK;
						state_q <= S_RED;
					end
				end
				S_RED: begin
					step_q <= CW'(WIDTH - 1);
					pend_mul_q <= 1'b0;
					red_q <= 1'b1;
					state_q <= S_STEP;
				end
				S_BASE: begin
					red_q <= 1'b0;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					bit_q <= CW'(WIDTH - 1);
					state_q <= S_SQ;
				end
				S_SQ: begin
					step_q <= CW'(WIDTH - 1);
					pend_mul_q <= stat.exp_bit;
					red_q <= 1'b0;
					state_q <= S_STEP;
				end
				S_MUL: begin
					step_q <= CW'(WIDTH - 1);
					pend_mul_q <= 1'b0;
					red_q <= 1'b0;
					state_q <= S_STEP;
				end
				S_STEP: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) state_q <= red_q ? S_BASE : S_NEXT;
				end
				S_NEXT: begin
					if (pend_mul_q) state_q <= S_MUL;
					else if (bit_q == '0) state_q <= S_SAVE;
					else begin
						bit_q <= bit_q - 1'b1;
						state_q <= S_SQ;
					end
				end
				S_SAVE: begin
					unique case (op_q)
						OP_LOAD_GA: begin
							op_q <= OP_LOAD_GB;
							state_q <= S_LOAD;
						end
						OP_LOAD_GB: begin
							op_q <= OP_LOAD_KEY;
							state_q <= S_LOAD;
						end
						default: begin
							done <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/diffie_hellman_key_exchange.sv
`timescale 1ns / 1ps
// Computes both public values and the shared key of a Diffie-Hellman exchange for one word
// of two secrets. Raise start while busy is low; done then pulses for one cycle with the
// results, which must be taken then. The results come from a bit-serial modular
// multiplier that takes one multiplier bit per cycle; it also reduces the generator once
// per word. A secret not below the modulus ends the word in the check state after start,
// with zero results.
module diffie_hellman_key_exchange #(
	parameter int unsigned WIDTH = dhke_pkg::WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [WIDTH-1:0] cfg_data,
	input  logic             start,
	input  logic [WIDTH-1:0] secret_a,
	input  logic [WIDTH-1:0] secret_b,
	output logic             busy,
	output logic             done,
	output logic [WIDTH-1:0] public_a,
	output logic [WIDTH-1:0] public_b,
	output logic [WIDTH-1:0] shared_key,
	output logic [1:0]       status
);
	import dhke_pkg::*;

	logic [WIDTH-1:0] modulus_q, generator_q;
	logic capture;
	dhke_cmd_t cmd;
	dhke_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= WIDTH'(23);
			generator_q <= WIDTH'(5);
		end else if (cfg_we) begin
			if (cfg_index == REG_MODULUS) modulus_q <= cfg_data;
			else generator_q <= cfg_data;
		end
	end

	dhke_ctrl #(.WIDTH(WIDTH)) u_ctrl (
		.clk, .arst_n, .start, .stat, .busy, .capture, .cmd, .done, .status
	);

	dhke_datapath #(.WIDTH(WIDTH)) u_dp (
		.clk, .capture, .secret_a, .secret_b, .modulus(modulus_q),
		.generator(generator_q), .cmd, .stat, .public_a, .public_b, .shared_key
	);
endmodule

// File: hw/rtl/dhke_checker.sv
`timescale 1ns / 1ps
module dhke_props (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status
);
	import dhke_pkg::*;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("no busy after start");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy at done");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_BAD_A || status == ST_BAD_B))
		else $error("bad status");
endmodule

bind diffie_hellman_key_exchange dhke_props u_chk (
	.clk, .arst_n, .start, .busy, .done, .status
);

// File: dv/dhke_checker.sv
`timescale 1ns / 1ps
module dhke_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] secret_a,
	input  logic [31:0] secret_b,
	input  logic        done,
	input  logic [31:0] public_a,
	input  logic [31:0] public_b,
	input  logic [31:0] shared_key,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending
);
	import dhke_pkg::*;

	typedef struct {
		logic [31:0] pub_a;
		logic [31:0] pub_b;
		logic [31:0] key;
		logic [1:0]  st;
	} exchange_t;

	exchange_t   key_q[$];
	logic [31:0] modulus_r;
	logic [31:0] generator_r;

	function automatic logic [31:0] power_mod(logic [31:0] base, logic [31:0] e,
			logic [31:0] m);
		logic [63:0] r;
		logic [63:0] b;
		r = 64'd1 % m;
		b = base % m;
		for (int i = 31; i >= 0; i--) begin
			r = (r * r) % m;
			if (e[i]) begin
				r = (r * b) % m;
			end
		end
		return r[31:0];
	endfunction

	function automatic exchange_t predict_exchange(logic [31:0] sa, logic [31:0] sb);
		exchange_t x;
		x = '{32'd0, 32'd0, 32'd0, ST_OK};
		if (sa >= modulus_r) begin
			x.st = ST_BAD_A;
		end else if (sb >= modulus_r) begin
			x.st = ST_BAD_B;
		end else begin
			x.pub_a = power_mod(generator_r, sa, modulus_r);
			x.pub_b = power_mod(generator_r, sb, modulus_r);
			x.key = power_mod(x.pub_b, sa, modulus_r);
		end
		return x;
	endfunction

	assign pending = key_q.size();

	always @(posedge clk or negedge arst_n) begin
		exchange_t got;
		exchange_t want;
		if (!arst_n) begin
			modulus_r <= 32'd23;
			generator_r <= 32'd5;
			fail_count <= 0;
			key_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MODULUS) begin
					modulus_r <= cfg_data;
				end else if (cfg_index == REG_GENERATOR) begin
					generator_r <= cfg_data;
				end
			end
			if (start && !busy) begin
				key_q.push_back(predict_exchange(secret_a, secret_b));
			end
			if (done) begin
				got = '{public_a, public_b, shared_key, status};
				if (key_q.size() == 0) begin
					$error("result word with no expectation waiting");
					fail_count <= fail_count + 1;
				end else begin
					want = key_q.pop_front();
					if (got.pub_a !== want.pub_a) begin
						$error("public_a: expected %0h, got %0h", want.pub_a, got.pub_a);
						fail_count <= fail_count + 1;
					end
					if (got.pub_b !== want.pub_b) begin
						$error("public_b: expected %0h, got %0h", want.pub_b, got.pub_b);
						fail_count <= fail_count + 1;
					end
					if (got.key !== want.key) begin
						$error("shared_key: expected %0h, got %0h", want.key, got.key);
						fail_count <= fail_count + 1;
					end
					if (got.st !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, got.st);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import dhke_pkg::*;

	localparam int STALL_LIMIT = 40000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        start;
	logic [31:0] secret_a;
	logic [31:0] secret_b;
	logic        busy;
	logic        done;
	logic [31:0] public_a;
	logic [31:0] public_b;
	logic [31:0] shared_key;
	logic [1:0]  status;
	int          fail_count;
	int          pending;
	int          idle_cycles;
	logic [31:0] modulus_now;

	diffie_hellman_key_exchange i_dut (.*);

	dhke_checker i_checker (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("diffie_hellman_key_exchange regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_word(logic [31:0] a, logic [31:0] b);
		int gap;
		logic taken;
		gap = $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		secret_a <= a;
		secret_b <= b;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_MODULUS) begin
			modulus_now = value;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_secret();
		logic [63:0] r;
		r = {$urandom, $urandom};
		if (modulus_now != 0 && $urandom_range(0, 9) < 8) begin
			return 32'(r % modulus_now);
		end
		return r[31:0];
	endfunction

	task automatic random_words(int count);
		for (int i = 0; i < count; i++) begin
			send_word(pick_secret(), pick_secret());
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MODULUS;
		cfg_data = '0;
		start = 1'b0;
		secret_a = '0;
		secret_b = '0;
		modulus_now = 32'd23;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(32'd0, 32'd0);
		send_word(32'd22, 32'd22);
		send_word(32'd6, 32'd15);
		send_word(32'd23, 32'd1);
		send_word(32'hFFFFFFFF, 32'd0);
		send_word(32'd3, 32'd23);
		send_word(32'd3, 32'hFFFFFFFF);
		send_word(32'd1, 32'd0);
		drain();

		write_reg(REG_MODULUS, 32'hFFFFFFFF);
		write_reg(REG_GENERATOR, $urandom);
		send_word(32'hFFFFFFFE, 32'hFFFFFFFE);
		send_word(32'hFFFFFFFF, 32'd5);
		send_word(32'h80000000, 32'h7FFFFFFF);
		drain();
		random_words(20);

		write_reg(REG_MODULUS, 32'hFFFFFFFB);
		write_reg(REG_GENERATOR, 32'd2);
		random_words(20);

		write_reg(REG_GENERATOR, 32'hFFFFFFFF);
		random_words(15);

		write_reg(REG_MODULUS, 32'd2);
		write_reg(REG_GENERATOR, 32'd0);
		send_word(32'd0, 32'd0);
		send_word(32'd1, 32'd1);
		send_word(32'd2, 32'd1);
		send_word(32'd1, 32'd2);
		drain();

		write_reg(REG_MODULUS, 32'd1);
		write_reg(REG_GENERATOR, 32'd7);
		send_word(32'd0, 32'd0);
		send_word(32'd0, 32'd1);
		drain();

		write_reg(REG_MODULUS, 32'd0);
		random_words(8);

		write_reg(REG_MODULUS, 32'd1009);
		write_reg(REG_GENERATOR, 32'd5000);
		random_words(20);

		write_reg(REG_MODULUS, 32'd65521);
		write_reg(REG_GENERATOR, 32'd17);
		random_words(20);

		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("diffie_hellman_key_exchange regression: pass");
		end else begin
			$display("diffie_hellman_key_exchange regression: fail");
		end
		$finish;
	end
endmodule

// File: sim.f
hw/rtl/dhke_pkg.sv
hw/rtl/dhke_datapath.sv
hw/rtl/dhke_ctrl.sv
hw/rtl/diffie_hellman_key_exchange.sv
hw/rtl/dhke_checker.sv
dv/dhke_checker.sv
dv/tb_top.sv
